@@ sv/lcns_pkg.sv @@
`default_nettype none
package lcns_pkg;

  // random bits per sample
  typedef enum logic [1:0] {
    MODE_8BIT  = 2'd0,
    MODE_12BIT = 2'd1,
    MODE_16BIT = 2'd2
  } sample_mode_e;

  // configuration register indexes
  localparam logic [2:0] REG_SAMPLE_MODE  = 3'd0;
  localparam logic [2:0] REG_TABLE_LENGTH = 3'd1;
  localparam logic [2:0] REG_TABLE_WORD_0 = 3'd2;
  localparam logic [2:0] REG_TABLE_WORD_1 = 3'd3;
  localparam logic [2:0] REG_TABLE_WORD_2 = 3'd4;
  localparam logic [2:0] REG_TABLE_WORD_3 = 3'd5;

  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned TABLE_WORDS = 4;
  localparam int unsigned ENTRY_W     = 16;
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned RAND_W      = 24;
  localparam int unsigned SAMPLE_W    = 5;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [1:0]       RESET_MODE   = 2'd2;
  localparam logic [LEN_W-1:0] RESET_LENGTH = 5'd12;

  typedef logic [SAMPLE_W-1:0] sample_t;

endpackage
`default_nettype wire

@@ sv/lwe_cdf_noise_sampler_core.sv @@
// LWE inverse-CDF noise sampler core
//
// Channels:
//   s_axis   random words in; tdata[23:0] random_bits, tuser first_only
//   m_axis   noise samples out; tdata[4:0] noise_sample (two's complement),
//            tlast marks the final sample of an input item
//   cfg      register writes (index, 64-bit data), always ready; write only
//            while the block is idle
// Path: an input item passes the input register, then the result register,
//   before its sample appears on m_axis.
// Throughput: one input item per cycle in 8-bit and 16-bit modes while
//   m_axis_tready is high; in 12-bit mode an item that yields two samples
//   occupies the single-sample output port until its second sample is taken,
//   and the next item cannot advance before then. The comparator bank
//   (TABLE_ENTRIES-1 comparators per lane, two lanes) is combinational.
// Reserved mode 3 consumes items and produces no samples.
// Reset: all pipeline stages empty, mode 16-bit, table length 12, table zero.
// Stall: while m_axis_tready is low the result register holds and the input
//   register still takes one more item, then s_axis_tready drops.
`default_nettype none
module lwe_cdf_noise_sampler_core #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // config write channel
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [lcns_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [lcns_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // input stream
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  wire logic [lcns_pkg::RAND_W-1:0]       s_axis_tdata_i,  // [23:0] random_bits
  input  wire logic                              s_axis_tuser_i,  // [0] first_only
  // output stream
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  output logic [lcns_pkg::OUT_TDATA_W-1:0]       m_axis_tdata_o,  // [4:0] noise_sample
  output logic                                   m_axis_tlast_o   // last_of_item
);
  import lcns_pkg::*;

  localparam int unsigned MAG_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CMP_N = TABLE_ENTRIES - 1;

  // configuration registers
  logic [1:0]                            mode_q;
  logic [LEN_W-1:0]                      len_q;
  logic [TABLE_WORDS-1:0][CFG_DATA_W-1:0] table_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= RESET_MODE;
      len_q   <= RESET_LENGTH;
      table_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_SAMPLE_MODE:  mode_q     <= cfg_data_i[1:0];
        REG_TABLE_LENGTH: len_q      <= cfg_data_i[LEN_W-1:0];
        REG_TABLE_WORD_0: table_q[0] <= cfg_data_i;
        REG_TABLE_WORD_1: table_q[1] <= cfg_data_i;
        REG_TABLE_WORD_2: table_q[2] <= cfg_data_i;
        REG_TABLE_WORD_3: table_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  logic              s1_valid_q, s1_valid_d;
  logic [RAND_W-1:0] s1_rand_q;
  logic              s1_first_q;
  logic              s1_advance;
  logic              out_free;
  logic              mode_rsvd;

  logic              out_valid_q, out_valid_d;
  logic              out_has2_q, out_has2_d;
  logic              out_last_q, out_last_d;
  sample_t           out_samp0_q, out_samp0_d;
  sample_t           out_samp1_q, out_samp1_d;

  assign mode_rsvd       = (mode_q != MODE_8BIT) && (mode_q != MODE_12BIT) &&
                           (mode_q != MODE_16BIT);
  assign out_free        = !out_valid_q || (m_axis_tready_i && !out_has2_q);
  assign s1_advance      = s1_valid_q && (out_free || mode_rsvd);
  assign s_axis_tready_o = !s1_valid_q || s1_advance;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      s1_valid_d = 1'b1;
    end else if (s1_advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      s1_rand_q  <= s_axis_tdata_i;
      s1_first_q <= s_axis_tuser_i;
    end
  end

  // lane values and signs per mode
  logic               narrow;
  logic               is_12;
  logic [ENTRY_W-1:0] val_a, val_b;
  logic               sign_a, sign_b;

  assign narrow = (mode_q == MODE_8BIT);
  assign is_12  = (mode_q == MODE_12BIT);
  assign sign_a = is_12 ? s1_rand_q[1] : s1_rand_q[0];
  assign sign_b = s1_rand_q[0];
  assign val_b  = {5'd0, s1_rand_q[12:2]};

  always_comb begin
    case (mode_q)
      MODE_8BIT:  val_a = {9'd0, s1_rand_q[7:1]};
      MODE_12BIT: val_a = {5'd0, s1_rand_q[23:13]};
      MODE_16BIT: val_a = {1'b0, s1_rand_q[15:1]};
      default:    val_a = '0;
    endcase
  end

  // clamped table length; entry j counts only when j+1 < length
  logic [LEN_W-1:0] len_cl;
  assign len_cl = (len_q > LEN_W'(TABLE_ENTRIES)) ? LEN_W'(TABLE_ENTRIES) : len_q;

  // comparator bank, two lanes
  logic [CMP_N-1:0]   hit_a, hit_b;
  logic [ENTRY_W-1:0] entry_eff [CMP_N];

  always_comb begin
    for (int j = 0; j < CMP_N; j++) begin
      entry_eff[j] = table_q[j / 4][16 * (j % 4) +: ENTRY_W];
      if (narrow) begin
        entry_eff[j] = {8'd0, entry_eff[j][7:0]};
      end
      hit_a[j] = (LEN_W'(j + 1) < len_cl) && (entry_eff[j] < val_a);
      hit_b[j] = (LEN_W'(j + 1) < len_cl) && (entry_eff[j] < val_b);
    end
  end

  // hit counts
  logic [MAG_W-1:0] mag_a, mag_b;

  always_comb begin
    mag_a = '0;
    mag_b = '0;
    for (int j = 0; j < CMP_N; j++) begin
      mag_a = mag_a + MAG_W'(hit_a[j]);
      mag_b = mag_b + MAG_W'(hit_b[j]);
    end
  end

  // apply sign
  sample_t mag5_a, mag5_b, samp_a, samp_b;

  assign mag5_a = SAMPLE_W'(mag_a);
  assign mag5_b = SAMPLE_W'(mag_b);
  assign samp_a = sign_a ? (SAMPLE_W'(0) - mag5_a) : mag5_a;
  assign samp_b = sign_b ? (SAMPLE_W'(0) - mag5_b) : mag5_b;

  // result register; holds up to two samples of one item
  always_comb begin
    out_valid_d = out_valid_q;
    out_has2_d  = out_has2_q;
    out_last_d  = out_last_q;
    out_samp0_d = out_samp0_q;
    out_samp1_d = out_samp1_q;
    if (s1_advance && !mode_rsvd) begin
      out_valid_d = 1'b1;
      out_has2_d  = is_12 && !s1_first_q;
      out_last_d  = !(is_12 && !s1_first_q);
      out_samp0_d = samp_a;
      out_samp1_d = samp_b;
    end else if (out_valid_q && m_axis_tready_i) begin
      if (out_has2_q) begin
        out_has2_d  = 1'b0;
        out_last_d  = 1'b1;
        out_samp0_d = out_samp1_q;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_has2_q  <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      out_has2_q  <= out_has2_d;
      out_last_q  <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_samp0_q <= out_samp0_d;
    out_samp1_q <= out_samp1_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W - SAMPLE_W){1'b0}}, out_samp0_q};
  assign m_axis_tlast_o  = out_last_q;

  // checks
  a_has2_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_has2_q |-> out_valid_q)
    else $error("second sample pending without a valid result");

  a_single_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_has2_q) |-> m_axis_tlast_o)
    else $error("sole pending sample not marked last");

  a_pair_first_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_has2_q |-> !m_axis_tlast_o)
    else $error("first of a pair marked last");

  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_has2_q && m_axis_tready_i) |=> (out_valid_q && m_axis_tlast_o))
    else $error("second sample of a pair lost");

  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> s1_valid_q)
    else $error("accepted item not held in input register");

endmodule
`default_nettype wire
